// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Each macro expands to a labeled concurrent assertion, or to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// check that the consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/i2cbm_pkg.sv =====
// Package for the I2C bit-level master: command and status codes, payload structs.
// No dependencies.
package i2cbm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_WAIT_ACK = 3'd4,
        CMD_READ     = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SDA_LOW  = 2'd1,
        ST_SDA_HIGH = 2'd2,
        ST_TIMEOUT  = 2'd3
    } t_status;

    localparam logic [7:0] ACK_WAIT_RESET = 8'd50;

    // last phase of the write sequence (eight bits, three slots each)
    localparam logic [4:0] WR_LAST_PHASE = 5'd24;
    // last phase of the read data bits
    localparam logic [4:0] RD_LAST_BIT_PHASE = 5'd17;
    localparam logic [4:0] RD_ACK_PHASE      = 5'd18;
    localparam logic [4:0] RD_ACK_HIGH_PHASE = 5'd19;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_level;
    } t_in_item;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        t_status    status;
        logic [7:0] rx_byte;
    } t_out_item;

endpackage

// ===== rtl/core/i2c_bit_level_master.sv =====
// I2C bit-level master: one bus slot per input transaction, one result per slot.
// The result of a slot appears in the output register in the cycle after acceptance.
// Throughput: one slot per cycle while the output does not stall; each step is a single
//   logic pass from command state to output register, so the next slot enters at once.
// Reset (synchronous, active low): idle, SCL and SDA released, ack wait limit 50.
// Depends on i2cbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2c_bit_level_master (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input slot channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i2cbm_pkg::t_in_item   i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i2cbm_pkg::t_out_item  o_out_data,
    // ack wait limit register
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata
);
    import i2cbm_pkg::*;

    // command sequencer state
    t_cmd       r_command, n_command;
    logic [4:0] r_phase,   n_phase;
    logic [7:0] r_shift,   n_shift;
    logic [7:0] r_wait,    n_wait;
    logic       r_scl,     n_scl;
    logic       r_sda,     n_sda;
    logic       r_ack,     n_ack;
    // position inside a write bit: set SDA, raise SCL, lower SCL
    logic [1:0] r_wk,      n_wk;

    logic [7:0] r_limit;

    // output register
    logic       r_out_valid;
    t_out_item  r_out, n_out;

    logic       in_accept;

    // slot step, after a new command is folded in
    t_cmd       cmd_eff;
    logic [4:0] phase_eff;
    logic [7:0] shift_eff;
    logic       ack_eff;
    logic       step_done;
    t_status    step_status;
    logic [7:0] step_rx;
    logic [4:0] wait_phase;
    logic [8:0] wait_next;

    // Take a new slot whenever the output register is free or drains this cycle.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Fold a new command into the state: only while idle and for a known mode.
    always_comb begin
        cmd_eff   = r_command;
        phase_eff = r_phase;
        shift_eff = r_shift;
        ack_eff   = r_ack;
        if (r_command == CMD_NONE && i_in_data.mode >= CMD_START &&
                i_in_data.mode <= CMD_READ) begin
            cmd_eff   = t_cmd'(i_in_data.mode);
            phase_eff = '0;
            if (i_in_data.mode == CMD_WRITE) begin
                shift_eff = i_in_data.tx_byte;
            end
            if (i_in_data.mode == CMD_READ) begin
                shift_eff = '0;
                ack_eff   = i_in_data.send_ack;
            end
        end
    end

    assign wait_next = {1'b0, r_wait} + 9'd1;

    // Pin action, data path and completion for this slot.
    always_comb begin
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_shift     = shift_eff;
        n_wait      = r_wait;
        n_ack       = ack_eff;
        n_wk        = r_wk;
        step_done   = 1'b0;
        step_status = ST_OK;
        step_rx     = '0;
        wait_phase  = phase_eff;
        unique case (cmd_eff)
            CMD_START: begin
                if (phase_eff == 5'd0) begin
                    n_sda = 1'b1;
                end else if (phase_eff == 5'd1) begin
                    // abort if the line is held low by someone else
                    if (!i_in_data.sda_level) begin
                        step_done   = 1'b1;
                        step_status = ST_SDA_LOW;
                    end else begin
                        n_scl = 1'b1;
                    end
                end else if (phase_eff == 5'd2) begin
                    n_sda = 1'b0;
                end else begin
                    step_done = 1'b1;
                    if (i_in_data.sda_level) begin
                        step_status = ST_SDA_HIGH;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
            end
            CMD_STOP: begin
                if (phase_eff == 5'd0) begin
                    n_scl = 1'b0;
                end else if (phase_eff == 5'd1) begin
                    n_sda = 1'b0;
                end else if (phase_eff == 5'd2) begin
                    n_scl = 1'b1;
                end else begin
                    n_sda     = 1'b1;
                    step_done = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (phase_eff == 5'd0) begin
                    n_scl = 1'b0;
                    n_wk  = 2'd0;
                end else begin
                    case (r_wk)
                        2'd0: begin
                            n_sda   = shift_eff[7];
                            n_shift = {shift_eff[6:0], 1'b0};
                            n_wk    = 2'd1;
                        end
                        2'd1: begin
                            n_scl = 1'b1;
                            n_wk  = 2'd2;
                        end
                        default: begin
                            n_scl = 1'b0;
                            n_wk  = 2'd0;
                            if (phase_eff >= WR_LAST_PHASE) begin
                                step_done = 1'b1;
                            end
                        end
                    endcase
                end
            end
            CMD_WAIT_ACK: begin
                if (phase_eff == 5'd0) begin
                    n_sda      = 1'b1;
                    wait_phase = 5'd1;
                end else if (phase_eff == 5'd1) begin
                    n_scl      = 1'b1;
                    n_wait     = '0;
                    wait_phase = 5'd2;
                end else if (phase_eff == 5'd2) begin
                    if (!i_in_data.sda_level) begin
                        n_scl     = 1'b0;
                        step_done = 1'b1;
                    end else if (wait_next > {1'b0, r_limit}) begin
                        // timeout: fall into the stop sequence
                        n_scl      = 1'b0;
                        wait_phase = 5'd3;
                    end else begin
                        n_wait = wait_next[7:0];
                    end
                end else if (phase_eff == 5'd3) begin
                    n_sda      = 1'b0;
                    wait_phase = 5'd4;
                end else if (phase_eff == 5'd4) begin
                    n_scl      = 1'b1;
                    wait_phase = 5'd5;
                end else begin
                    n_sda       = 1'b1;
                    step_done   = 1'b1;
                    step_status = ST_TIMEOUT;
                end
            end
            CMD_READ: begin
                if (phase_eff == 5'd0) begin
                    n_scl = 1'b0;
                end else if (phase_eff == 5'd1) begin
                    n_sda = 1'b1;
                end else if (phase_eff <= RD_LAST_BIT_PHASE) begin
                    if (!phase_eff[0]) begin
                        n_scl = 1'b1;
                    end else begin
                        // sample SDA while SCL is high, then drop SCL
                        n_shift = {shift_eff[6:0], i_in_data.sda_level};
                        n_scl   = 1'b0;
                    end
                end else if (phase_eff == RD_ACK_PHASE) begin
                    n_sda = ~ack_eff;
                end else if (phase_eff == RD_ACK_HIGH_PHASE) begin
                    n_scl = 1'b1;
                end else begin
                    n_scl     = 1'b0;
                    step_done = 1'b1;
                    step_rx   = shift_eff;
                end
            end
            default: begin
                // idle: hold pins, report nothing
            end
        endcase
    end

    // Next command state.
    always_comb begin
        n_command = cmd_eff;
        n_phase   = '0;
        if (step_done) begin
            n_command = CMD_NONE;
            n_phase   = '0;
        end else begin
            unique case (cmd_eff)
                CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: n_phase = phase_eff + 5'd1;
                CMD_WAIT_ACK:                             n_phase = wait_phase;
                default: begin
                    n_command = CMD_NONE;
                    n_phase   = '0;
                end
            endcase
        end
    end

    // Result of this slot.
    always_comb begin
        n_out.scl_drive = n_scl;
        n_out.sda_drive = n_sda;
        n_out.busy_res  = (n_command != CMD_NONE);
        n_out.done_res  = step_done;
        n_out.status    = step_status;
        n_out.rx_byte   = step_rx;
    end

    // Sequencer state: advance only on an accepted slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command <= CMD_NONE;
            r_phase   <= '0;
            r_shift   <= '0;
            r_wait    <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_ack     <= 1'b0;
            r_wk      <= '0;
        end else if (in_accept) begin
            r_command <= n_command;
            r_phase   <= n_phase;
            r_shift   <= n_shift;
            r_wait    <= n_wait;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_ack     <= n_ack;
            r_wk      <= n_wk;
        end
    end

    // Ack wait limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ACK_WAIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Output register: load on accept, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    `ASSERT_IMPLY(a_done_not_busy, i_clk, i_rst_n,
        o_out_valid && o_out_data.done_res, !o_out_data.busy_res,
        "finished slot reports busy")
    `ASSERT_IMPLY(a_status_needs_done, i_clk, i_rst_n,
        o_out_valid && o_out_data.status != ST_OK, o_out_data.done_res,
        "error status without done")
    `ASSERT_IMPLY(a_write_step_range, i_clk, i_rst_n,
        r_command == CMD_WRITE && r_phase != 5'd0, r_wk != 2'd3,
        "write bit step out of range")
    `ASSERT_NEXT(a_accept_loads_out, i_clk, i_rst_n,
        in_accept, o_out_valid,
        "accepted slot left no result")

endmodule
